// ----- rtl/iasmd_pkg.sv -----
// Shared types and constants for the integer add/sub/mul/div unit.
package iasmd_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture a new request
        logic step;    // one multiply or divide bit step
        logic finish;  // write the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic iterative;  // captured request is a multiply or divide
    } status_t;

endpackage

// ----- rtl/int32_add_sub_mul_div_unit.sv -----
// Top level of the signed integer add/sub/mul/div unit.
//
//  channel  signals                              direction
//  in       in_valid, in_ready, func,            request in
//           operand_a, operand_b
//  out      out_valid, out_ready, result         result out
//
// Add and subtract: the sum or difference is formed at accept and goes to the output
// register once that register is free. Multiply (shift-add) and divide (restoring)
// first step through the operand bits, one bit a cycle through
// the shared accumulator of the datapath.
// One request in flight; the next is taken once the result is in the output
// register, which holds it while out_ready is low.
// Reset clears the controller only; no clearing pass.
module int32_add_sub_mul_div_unit
    import iasmd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] result
);

    cmd_t    cmd;
    status_t status;

    iasmd_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    iasmd_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .result    (result)
    );

endmodule

// ----- rtl/iasmd_dp.sv -----
// Datapath: operand registers, shift-add multiplier, restoring divider, output register.
module iasmd_dp
    import iasmd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic signed [DATA_WIDTH-1:0] result
);

    func_t                 func_reg;
    logic [DATA_WIDTH-1:0] a_reg;    // multiplicand, or dividend shifting out / quotient in
    logic [DATA_WIDTH-1:0] b_reg;    // multiplier, or divisor magnitude
    logic [DATA_WIDTH-1:0] acc_reg;  // product, remainder, or sum/difference
    logic                  neg_reg;
    logic                  zero_reg;
    logic [DATA_WIDTH-1:0] result_reg;

    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] quot;

    always_comb
    begin
        ua    = $unsigned(operand_a);
        ub    = $unsigned(operand_b);
        mag_a = ua[DATA_WIDTH-1] ? (~ua + 1'b1) : ua;
        mag_b = ub[DATA_WIDTH-1] ? (~ub + 1'b1) : ub;
        trial = {acc_reg, a_reg[DATA_WIDTH-1]};
        diff  = trial - {1'b0, b_reg};
        fits  = (trial >= {1'b0, b_reg});
        if (zero_reg)
        begin
            quot = '0;
        end
        else if (neg_reg)
        begin
            quot = ~a_reg + 1'b1;
        end
        else
        begin
            quot = a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            neg_reg  <= ua[DATA_WIDTH-1] ^ ub[DATA_WIDTH-1];
            zero_reg <= (ua == '0) || (ub == '0);
            unique case (func_t'(func))
                FUNC_ADD:
                begin
                    a_reg   <= ua;
                    b_reg   <= ub;
                    acc_reg <= ua + ub;
                end
                FUNC_SUB:
                begin
                    a_reg   <= ua;
                    b_reg   <= ub;
                    acc_reg <= ua - ub;
                end
                FUNC_MUL:
                begin
                    a_reg   <= ua;
                    b_reg   <= ub;
                    acc_reg <= '0;
                end
                FUNC_DIV:
                begin
                    a_reg   <= mag_a;
                    b_reg   <= mag_b;
                    acc_reg <= '0;
                end
                default:
                begin
                    a_reg   <= ua;
                    b_reg   <= ub;
                    acc_reg <= '0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (func_reg == FUNC_DIV)
            begin
                if (fits)
                begin
                    acc_reg <= diff[DATA_WIDTH-1:0];
                    a_reg   <= {a_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= trial[DATA_WIDTH-1:0];
                    a_reg   <= {a_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
        end

        if (cmd.finish)
        begin
            result_reg <= (func_reg == FUNC_DIV) ? quot : acc_reg;
        end
    end

    assign status.iterative = (func_reg == FUNC_MUL) || (func_reg == FUNC_DIV);
    assign result           = $signed(result_reg);

endmodule

// ----- rtl/iasmd_ctrl.sv -----
// Controller: request sequencing, bit-step counter and output valid.
module iasmd_ctrl
    import iasmd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic          steps_done;
    logic          out_free;

    assign steps_done = !status.iterative || (cnt_reg == CW'(DATA_WIDTH));
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.step   = (state_reg == ST_RUN) && !steps_done;
        cmd.finish = (state_reg == ST_RUN) && steps_done && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (cmd.step)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (cmd.finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    // no more bit steps than result bits
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cnt_reg < CW'(DATA_WIDTH)))
        else $error("step count overrun");

    // every request starts its step count from zero
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("request did not start cleanly");

    // no new request while a step is in progress
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.step && !cmd.finish)
        else $error("accepting while busy");
`endif

endmodule

// ----- sim/tb.sv -----
// Testbench for the integer add/sub/mul/div unit: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb;
    import iasmd_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_COUNT = 900;
    localparam logic [31:0] MAX_POS      = 32'h7FFF_FFFF;
    localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE    = 32'hFFFF_FFFF;

    typedef struct {
        func_t       op;
        logic [31:0] a;
        logic [31:0] b;
        int          gap_before;
        bit          drain_first;
    } alu_request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = 2'd0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] result;

    alu_request_t requests_to_send[$];
    logic [31:0]  results_due[$];
    alu_request_t next_req;
    logic [31:0]  want;
    int           gap_waited = 0;
    int           failures = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           stall_left = 0;
    int           long_hold_left = 0;
    bit           long_hold_done = 0;
    bit           calm = 0;

    int32_add_sub_mul_div_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] compute_alu_result(func_t op, logic [31:0] a,
                                                       logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quot;
        case (op)
            FUNC_ADD: return a + b;
            FUNC_SUB: return a - b;
            FUNC_MUL: return a * b;
            default:
            begin
                if (a == 0 || b == 0)
                    return '0;
                // magnitudes as unsigned so the most negative value divides exactly
                mag_a = a[31] ? -a : a;
                mag_b = b[31] ? -b : b;
                quot  = mag_a / mag_b;
                return (a[31] ^ b[31]) ? -quot : quot;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: v = $urandom;
            10, 11, 12, 13: v = $urandom_range(0, 200) - 100;
            14, 15, 16:
            begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 32'd1;
                    2: v = MINUS_ONE;
                    3: v = MAX_POS;
                    default: v = MOST_NEG;
                endcase
            end
            default:
            begin
                // spread of magnitudes keeps divide quotients interesting
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic void queue_request(func_t op, logic [31:0] a, logic [31:0] b,
                                          int gap, bit drain);
        alu_request_t req;
        req.op          = op;
        req.a           = a;
        req.b           = b;
        req.gap_before  = gap;
        req.drain_first = drain;
        requests_to_send.push_back(req);
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FUNC_ADD;
            operand_a  <= '0;
            operand_b  <= '0;
            gap_waited = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                results_due.push_back(compute_alu_result(func_t'(func), operand_a, operand_b));
            if (!in_valid || in_ready)
            begin
                if (requests_to_send.size() > 0
                    && gap_waited >= requests_to_send[0].gap_before
                    && !(requests_to_send[0].drain_first && results_due.size() > 0))
                begin
                    next_req   = requests_to_send.pop_front();
                    in_valid   <= 1'b1;
                    func       <= next_req.op;
                    operand_a  <= next_req.a;
                    operand_b  <= next_req.b;
                    gap_waited = 0;
                end
                else
                begin
                    // junk on the payload while nothing is offered
                    in_valid  <= 1'b0;
                    func      <= 2'($urandom_range(0, 3));
                    operand_a <= $urandom;
                    operand_b <= $urandom;
                    if (requests_to_send.size() > 0
                        && gap_waited < requests_to_send[0].gap_before)
                        gap_waited++;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    note_failure($sformatf("result %h with no request outstanding", result));
                else
                begin
                    want = results_due.pop_front();
                    if (result !== want)
                        note_failure($sformatf("result mismatch: expected %h, got %h",
                                               want, result));
                end
                results_seen++;
                // one long hold-off so the unit backs up and drops in_ready
                if (results_seen == 40 && !long_hold_done)
                begin
                    long_hold_left = 400;
                    long_hold_done = 1;
                end
            end
            if (cycle_count % 128 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int gap;
        bit drain;

        // overflow wrap on add, subtract and multiply
        queue_request(FUNC_ADD, MAX_POS, 32'd1, pick_gap(), 0);
        queue_request(FUNC_ADD, MOST_NEG, MOST_NEG, pick_gap(), 0);
        queue_request(FUNC_ADD, MINUS_ONE, 32'd1, pick_gap(), 0);
        queue_request(FUNC_ADD, MINUS_ONE, MINUS_ONE, pick_gap(), 0);
        queue_request(FUNC_SUB, MOST_NEG, 32'd1, pick_gap(), 0);
        queue_request(FUNC_SUB, 32'd0, MOST_NEG, pick_gap(), 0);
        queue_request(FUNC_SUB, MAX_POS, MINUS_ONE, pick_gap(), 0);
        queue_request(FUNC_MUL, MAX_POS, MAX_POS, pick_gap(), 0);
        queue_request(FUNC_MUL, MOST_NEG, MINUS_ONE, pick_gap(), 0);
        queue_request(FUNC_MUL, MINUS_ONE, MINUS_ONE, pick_gap(), 0);
        queue_request(FUNC_MUL, 32'd12345, 32'd0, pick_gap(), 0);
        queue_request(FUNC_MUL, 32'h0001_0000, 32'h0001_0000, pick_gap(), 0);
        // divide: sign combinations, zero divisor and dividend, most negative dividend
        queue_request(FUNC_DIV, 32'd7, 32'd2, pick_gap(), 0);
        queue_request(FUNC_DIV, -32'sd7, 32'd2, pick_gap(), 0);
        queue_request(FUNC_DIV, 32'd7, -32'sd2, pick_gap(), 0);
        queue_request(FUNC_DIV, -32'sd7, -32'sd2, pick_gap(), 0);
        queue_request(FUNC_DIV, 32'd100, 32'd0, pick_gap(), 0);
        queue_request(FUNC_DIV, 32'd0, 32'd5, pick_gap(), 0);
        queue_request(FUNC_DIV, 32'd0, 32'd0, pick_gap(), 0);
        queue_request(FUNC_DIV, MOST_NEG, MINUS_ONE, pick_gap(), 0);
        queue_request(FUNC_DIV, MOST_NEG, 32'd1, pick_gap(), 0);
        queue_request(FUNC_DIV, MOST_NEG, MOST_NEG, pick_gap(), 0);
        queue_request(FUNC_DIV, MAX_POS, MOST_NEG, pick_gap(), 0);
        queue_request(FUNC_DIV, MOST_NEG, 32'd3, pick_gap(), 0);
        queue_request(FUNC_DIV, MAX_POS, 32'd1, pick_gap(), 0);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            // a stretch of back-to-back requests
            gap   = (i >= 300 && i < 400) ? 0 : pick_gap();
            drain = (i == 0) || (i == 450) || ($urandom_range(0, 149) == 0);
            queue_request(func_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                          gap, drain);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_to_send.size() > 0 || in_valid || results_due.size() > 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (results_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", results_due.size()));
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
